[design/bbas_pkg.sv]
`timescale 1ns / 1ps
// Shared types, sizing constants and helper functions for the bitmap block allocator store.
// Depends on nothing; every other design file refers to it by scoped names.

package bbas_pkg;

  // Store geometry.
  localparam int unsigned NUM_BLOCKS      = 255;
  localparam int unsigned WORDS_PER_BLOCK = 32;
  localparam int unsigned MEM_DEPTH       = NUM_BLOCKS * WORDS_PER_BLOCK;
  localparam int unsigned ADDR_W          = $clog2(MEM_DEPTH);

  // Request and response field widths.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BLK_W    = 8;
  localparam int unsigned WIDX_W   = 5;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 3;

  // The allocation map is kept as chunks of 32 bits, one chunk searched per cycle.
  localparam int unsigned CHUNK_W    = 32;
  localparam int unsigned BIT_W      = $clog2(CHUNK_W);
  localparam int unsigned NUM_CHUNKS = (NUM_BLOCKS + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned CIDX_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_REQUEST = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_READ    = 3'd3,
    CMD_WRITE   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_RANGE   = 3'd2,
    STAT_TAKEN   = 3'd3,
    STAT_NOT_ALL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic exec;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic is_alloc;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

  // Bits of a chunk that map to existing blocks.
  function automatic logic [CHUNK_W-1:0] chunk_mask(input logic [CIDX_W-1:0] c);
    logic [CHUNK_W-1:0] m;
    for (int b = 0; b < CHUNK_W; b++) begin
      m[b] = ((int'(c) * CHUNK_W + b) < NUM_BLOCKS);
    end
    return m;
  endfunction

endpackage

[design/bbas_req_if.sv]
`timescale 1ns / 1ps
// Command channel interface: valid/ready handshake and the command payload.
// Widths come from bbas_pkg.

interface bbas_req_if;
  logic                          valid;
  logic                          ready;
  logic [bbas_pkg::CMD_W-1:0]    command;
  logic [bbas_pkg::BLK_W-1:0]    blk_num;
  logic [bbas_pkg::WIDX_W-1:0]   word_index;
  logic [bbas_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, command, blk_num, word_index, write_data, input ready);
  modport sink   (input valid, command, blk_num, word_index, write_data, output ready);
endinterface

[design/bbas_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel interface: valid/ready handshake and the result payload.
// Widths come from bbas_pkg.

interface bbas_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bbas_pkg::STATUS_W-1:0] status;
  logic [bbas_pkg::BLK_W-1:0]    granted_block;
  logic [bbas_pkg::DATA_W-1:0]   read_data;
  logic [bbas_pkg::BLK_W-1:0]    used_count;
  logic [bbas_pkg::BLK_W-1:0]    free_count;

  modport source (output valid, status, granted_block, read_data, used_count, free_count,
                  input ready);
  modport sink   (input valid, status, granted_block, read_data, used_count, free_count,
                  output ready);
endinterface

[design/bbas_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine of the allocator store.
// Uses bbas_pkg for the state enum and the command/status structs.

module bbas_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  bbas_pkg::dp_stat_t   stat_i,
  output bbas_pkg::ctrl_cmd_t  cmd_o
);

  bbas_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbas_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      bbas_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = bbas_pkg::S_IDLE;
        end
      end
      bbas_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = bbas_pkg::S_EXEC;
        end
      end
      bbas_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.is_alloc ? bbas_pkg::S_SCAN : bbas_pkg::S_DONE;
      end
      bbas_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = bbas_pkg::S_DONE;
        end
      end
      bbas_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = bbas_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bbas_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/bbas_dp.sv]
`timescale 1ns / 1ps
// Datapath: request registers, allocation bitmap, used counter, word store and result register.
// Driven by bbas_ctrl through bbas_pkg::ctrl_cmd_t; uses bbas_pkg constants and types.

module bbas_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bbas_pkg::ctrl_cmd_t               cmd_i,
  output bbas_pkg::dp_stat_t                stat_o,
  input  logic [bbas_pkg::CMD_W-1:0]        command_i,
  input  logic [bbas_pkg::BLK_W-1:0]        blk_num_i,
  input  logic [bbas_pkg::WIDX_W-1:0]       word_index_i,
  input  logic [bbas_pkg::DATA_W-1:0]       write_data_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic [bbas_pkg::STATUS_W-1:0]     status_o,
  output logic [bbas_pkg::BLK_W-1:0]        granted_block_o,
  output logic [bbas_pkg::DATA_W-1:0]       read_data_o,
  output logic [bbas_pkg::BLK_W-1:0]        used_count_o,
  output logic [bbas_pkg::BLK_W-1:0]        free_count_o
);

  localparam int unsigned CHUNK_W = bbas_pkg::CHUNK_W;
  localparam int unsigned BIT_W   = bbas_pkg::BIT_W;
  localparam int unsigned CIDX_W  = bbas_pkg::CIDX_W;
  localparam int unsigned ADDR_W  = bbas_pkg::ADDR_W;
  localparam int unsigned BLK_W   = bbas_pkg::BLK_W;

  // Latched request.
  logic [bbas_pkg::CMD_W-1:0]   command_q;
  logic [BLK_W-1:0]             blk_num_q;
  logic [bbas_pkg::WIDX_W-1:0]  word_index_q;
  logic [bbas_pkg::DATA_W-1:0]  write_data_q;

  // Command state.
  bbas_pkg::status_e            res_status_q, res_status_d;
  logic [BLK_W-1:0]             granted_q, granted_d;
  logic                         rd_hit_q, rd_hit_d;
  logic [CIDX_W-1:0]            scan_q, scan_d;
  logic [BLK_W-1:0]             used_q, used_d;
  logic [ADDR_W-1:0]            clr_q;

  // Allocation bitmap, one chunk per entry.
  logic [CHUNK_W-1:0]           map_q [bbas_pkg::NUM_CHUNKS];

  // Word store.
  logic [bbas_pkg::DATA_W-1:0]  mem_q [bbas_pkg::MEM_DEPTH];
  logic [bbas_pkg::DATA_W-1:0]  rdata_q;

  // Result register.
  logic                         out_valid_q;
  logic [bbas_pkg::STATUS_W-1:0] out_status_q;
  logic [BLK_W-1:0]             out_granted_q;
  logic [bbas_pkg::DATA_W-1:0]  out_rdata_q;
  logic [BLK_W-1:0]             out_used_q;
  logic [BLK_W-1:0]             out_free_cnt_q;

  logic                         id_ok;
  logic                         w_ok;
  logic [CIDX_W-1:0]            id_chunk;
  logic [BIT_W-1:0]             id_bit;
  logic [CIDX_W-1:0]            map_idx;
  logic [CHUNK_W-1:0]           map_rd;
  logic [CHUNK_W-1:0]           map_wr;
  logic                         map_we;
  logic [CHUNK_W-1:0]           avail;
  logic                         scan_hit;
  logic [BIT_W-1:0]             scan_pos;
  logic                         scan_last;
  logic                         mem_we;
  logic                         mem_re;
  logic [ADDR_W-1:0]            req_addr;
  logic [ADDR_W-1:0]            mem_addr;
  logic [bbas_pkg::DATA_W-1:0]  mem_wdata;
  logic                         out_free;

  assign id_ok    = (int'(blk_num_q) < bbas_pkg::NUM_BLOCKS);
  assign w_ok     = (int'(word_index_q) < bbas_pkg::WORDS_PER_BLOCK);
  assign id_chunk = CIDX_W'(blk_num_q >> BIT_W);
  assign id_bit   = blk_num_q[BIT_W-1:0];
  assign map_idx  = cmd_i.scan ? scan_q : id_chunk;
  assign map_rd   = map_q[map_idx];

  assign scan_last = (scan_q == CIDX_W'(bbas_pkg::NUM_CHUNKS - 1));
  assign avail     = ~map_rd & bbas_pkg::chunk_mask(scan_q);

  // Lowest free block in the chunk under scan.
  always_comb begin
    scan_pos = '0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        scan_pos = BIT_W'(b);
      end
    end
  end
  assign scan_hit = |avail;

  assign req_addr = ADDR_W'(ADDR_W'(blk_num_q) * ADDR_W'(bbas_pkg::WORDS_PER_BLOCK))
                    + ADDR_W'(word_index_q);

  always_comb begin
    res_status_d = res_status_q;
    granted_d    = granted_q;
    rd_hit_d     = rd_hit_q;
    scan_d       = scan_q;
    used_d       = used_q;
    map_wr       = map_rd;
    map_we       = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    if (cmd_i.exec) begin
      res_status_d = bbas_pkg::STAT_OK;
      granted_d    = '0;
      rd_hit_d     = 1'b0;
      scan_d       = '0;
      case (command_q)
        bbas_pkg::CMD_ALLOC: begin
          res_status_d = bbas_pkg::STAT_FULL;
        end
        bbas_pkg::CMD_REQUEST: begin
          if (!id_ok) begin
            res_status_d = bbas_pkg::STAT_RANGE;
          end else if (map_rd[id_bit]) begin
            res_status_d = bbas_pkg::STAT_TAKEN;
          end else begin
            map_wr[id_bit] = 1'b1;
            map_we         = 1'b1;
            used_d         = used_q + 1'b1;
          end
        end
        bbas_pkg::CMD_RELEASE: begin
          if (!id_ok) begin
            res_status_d = bbas_pkg::STAT_RANGE;
          end else if (!map_rd[id_bit]) begin
            res_status_d = bbas_pkg::STAT_NOT_ALL;
          end else begin
            map_wr[id_bit] = 1'b0;
            map_we         = 1'b1;
            used_d         = used_q - 1'b1;
          end
        end
        bbas_pkg::CMD_READ: begin
          if (!id_ok || !w_ok) begin
            res_status_d = bbas_pkg::STAT_RANGE;
          end else if (!map_rd[id_bit]) begin
            res_status_d = bbas_pkg::STAT_NOT_ALL;
          end else begin
            mem_re   = 1'b1;
            rd_hit_d = 1'b1;
          end
        end
        bbas_pkg::CMD_WRITE: begin
          if (!id_ok || !w_ok) begin
            res_status_d = bbas_pkg::STAT_RANGE;
          end else begin
            mem_we = 1'b1;
          end
        end
        default: begin
          res_status_d = bbas_pkg::STAT_OK;
        end
      endcase
    end else if (cmd_i.scan) begin
      if (scan_hit) begin
        map_wr[scan_pos] = 1'b1;
        map_we           = 1'b1;
        used_d           = used_q + 1'b1;
        granted_d        = BLK_W'({scan_q, scan_pos});
        res_status_d     = bbas_pkg::STAT_OK;
      end else if (!scan_last) begin
        scan_d = scan_q + 1'b1;
      end
    end
  end

  // The clearing sweep owns the store port until it finishes.
  assign mem_addr  = cmd_i.clr_step ? clr_q : req_addr;
  assign mem_wdata = cmd_i.clr_step ? '0 : write_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we || cmd_i.clr_step) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < bbas_pkg::NUM_CHUNKS; c++) begin
        map_q[c] <= '0;
      end
      used_q       <= '0;
      clr_q        <= '0;
      scan_q       <= '0;
      res_status_q <= bbas_pkg::STAT_OK;
      granted_q    <= '0;
      rd_hit_q     <= 1'b0;
    end else begin
      if (map_we) begin
        map_q[map_idx] <= map_wr;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      used_q       <= used_d;
      scan_q       <= scan_d;
      res_status_q <= res_status_d;
      granted_q    <= granted_d;
      rd_hit_q     <= rd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      command_q    <= command_i;
      blk_num_q    <= blk_num_i;
      word_index_q <= word_index_i;
      write_data_q <= write_data_i;
    end
  end

  assign out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q   <= res_status_q;
      out_granted_q  <= granted_q;
      out_rdata_q    <= rd_hit_q ? rdata_q : '0;
      out_used_q     <= used_q;
      out_free_cnt_q <= BLK_W'(bbas_pkg::NUM_BLOCKS) - used_q;
    end
  end

  assign stat_o.clr_done  = (clr_q == ADDR_W'(bbas_pkg::MEM_DEPTH - 1));
  assign stat_o.is_alloc  = (command_q == bbas_pkg::CMD_ALLOC);
  assign stat_o.scan_done = scan_hit || scan_last;
  assign stat_o.out_free  = out_free;

  assign rsp_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_block_o = out_granted_q;
  assign read_data_o     = out_rdata_q;
  assign used_count_o    = out_used_q;
  assign free_count_o    = out_free_cnt_q;

endmodule

[design/bitmap_block_allocator_store.sv]
`timescale 1ns / 1ps
// Top level of the bitmap block allocator store: sequencer plus datapath.
// Depends on bbas_pkg, bbas_req_if, bbas_rsp_if, bbas_ctrl and bbas_dp.
//
//   Channel | Direction | Carries
//   --------+-----------+-------------------------------------------------------
//   req_i   | in        | command, blk_num, word_index, write_data
//   rsp_o   | out       | status, granted_block, read_data, used_count, free_count
//
// Release, request, read, write and unused commands go from an accepted request through
// execute to the result hand-off; allocate also searches the allocation map one 32-bit
// chunk a cycle between the two, until a free block is found or the last chunk is done.
// After reset a clearing pass zeroes the word store one word a cycle, and no
// request is accepted until it is done. A finished result
// waits in the output register; a new request is accepted meanwhile, and only its
// own result waits for the output register to be taken.

module bitmap_block_allocator_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbas_req_if.sink    req_i,
  bbas_rsp_if.source  rsp_o
);

  // Command and status bundles between the sequencer and the datapath.
  bbas_pkg::ctrl_cmd_t ctrl_cmd;
  bbas_pkg::dp_stat_t  dp_stat;

  // The sequencer walks each request through execute, optional bitmap scan and
  // result hand-off.
  bbas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  // The datapath holds the bitmap, the used counter, the word store and the
  // result register.
  bbas_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .command_i       (req_i.command),
    .blk_num_i       (req_i.blk_num),
    .word_index_i    (req_i.word_index),
    .write_data_i    (req_i.write_data),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .status_o        (rsp_o.status),
    .granted_block_o (rsp_o.granted_block),
    .read_data_o     (rsp_o.read_data),
    .used_count_o    (rsp_o.used_count),
    .free_count_o    (rsp_o.free_count)
  );

endmodule

[bench/bitmap_block_allocator_store_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_block_allocator_store: directed and random commands.
// A mirror of the allocation map and the word store predicts every response.
// Depends on bbas_pkg, bbas_req_if, bbas_rsp_if and the design top level.

module bitmap_block_allocator_store_test;

  // The clearing pass after reset and the allocate scans add to the run time, as does
  // random idling on both sides.
  // This limit is several times the slowest correct run.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT     = 33;

  // Codes 5 to 7 are not commands. The block must answer them with ok and change nothing.
  localparam logic [bbas_pkg::CMD_W-1:0]  CMD_SPARE_FIRST = 3'd5;
  localparam logic [bbas_pkg::CMD_W-1:0]  CMD_SPARE_LAST  = 3'd7;
  localparam logic [bbas_pkg::BLK_W-1:0]  BLK_NUM_MAX     = '1;
  localparam logic [bbas_pkg::DATA_W-1:0] WORD_ONES       = '1;

  typedef struct packed {
    logic [bbas_pkg::CMD_W-1:0]  command;
    logic [bbas_pkg::BLK_W-1:0]  blk_num;
    logic [bbas_pkg::WIDX_W-1:0] word_index;
    logic [bbas_pkg::DATA_W-1:0] write_data;
  } store_request_t;

  typedef struct packed {
    bbas_pkg::status_e           status;
    logic [bbas_pkg::BLK_W-1:0]  granted_block;
    logic [bbas_pkg::DATA_W-1:0] read_data;
    logic [bbas_pkg::BLK_W-1:0]  used_count;
    logic [bbas_pkg::BLK_W-1:0]  free_count;
  } store_response_t;

  // Random traffic comes in phases. Fill drives the store to full. Drain empties it again.
  typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} traffic_mode_e;

  // The mirror keeps its own copy of the store's state. Every accepted request updates it
  // at once, in the order the block accepted them. The mirror also queues the response
  // each request must produce.
  class block_store_mirror;
    bit                        block_taken [bbas_pkg::NUM_BLOCKS];
    bit [bbas_pkg::DATA_W-1:0] block_words [bbas_pkg::MEM_DEPTH];
    int unsigned               used_blocks;
    store_response_t           due_responses [$];
    int unsigned               mismatches;

    function void note_request(store_request_t req);
      store_response_t rsp;
      bit              id_ok;
      bit              widx_ok;
      bit              found;
      int unsigned     addr;
      int unsigned     free_blocks;
      rsp         = '0;
      rsp.status  = bbas_pkg::STAT_OK;
      id_ok       = req.blk_num < bbas_pkg::NUM_BLOCKS;
      widx_ok     = req.word_index < bbas_pkg::WORDS_PER_BLOCK;
      addr        = int'(req.blk_num) * bbas_pkg::WORDS_PER_BLOCK + int'(req.word_index);
      found       = 1'b0;
      case (req.command)
        bbas_pkg::CMD_ALLOC: begin
          // The lowest-numbered free block wins.
          rsp.status = bbas_pkg::STAT_FULL;
          for (int b = 0; b < bbas_pkg::NUM_BLOCKS && !found; b++) begin
            if (!block_taken[b]) begin
              block_taken[b]    = 1'b1;
              used_blocks++;
              rsp.granted_block = b[bbas_pkg::BLK_W-1:0];
              rsp.status        = bbas_pkg::STAT_OK;
              found             = 1'b1;
            end
          end
        end
        bbas_pkg::CMD_REQUEST: begin
          if (!id_ok) begin
            rsp.status = bbas_pkg::STAT_RANGE;
          end else if (block_taken[req.blk_num]) begin
            rsp.status = bbas_pkg::STAT_TAKEN;
          end else begin
            block_taken[req.blk_num] = 1'b1;
            used_blocks++;
          end
        end
        bbas_pkg::CMD_RELEASE: begin
          if (!id_ok) begin
            rsp.status = bbas_pkg::STAT_RANGE;
          end else if (!block_taken[req.blk_num]) begin
            rsp.status = bbas_pkg::STAT_NOT_ALL;
          end else begin
            block_taken[req.blk_num] = 1'b0;
            used_blocks--;
          end
        end
        bbas_pkg::CMD_READ: begin
          if (!id_ok || !widx_ok) begin
            rsp.status = bbas_pkg::STAT_RANGE;
          end else if (!block_taken[req.blk_num]) begin
            rsp.status = bbas_pkg::STAT_NOT_ALL;
          end else begin
            rsp.read_data = block_words[addr];
          end
        end
        bbas_pkg::CMD_WRITE: begin
          // A write does not check whether the block is allocated.
          if (!id_ok || !widx_ok) begin
            rsp.status = bbas_pkg::STAT_RANGE;
          end else begin
            block_words[addr] = req.write_data;
          end
        end
        default: ;
      endcase
      free_blocks    = bbas_pkg::NUM_BLOCKS - used_blocks;
      rsp.used_count = used_blocks[bbas_pkg::BLK_W-1:0];
      rsp.free_count = free_blocks[bbas_pkg::BLK_W-1:0];
      due_responses.push_back(rsp);
    endfunction

    function void check_response(store_response_t got);
      store_response_t want;
      if (due_responses.size() == 0) begin
        mismatches++;
        $error("response with no request outstanding: status %0d", got.status);
        return;
      end
      want = due_responses.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        $error("status: expected %0d, got %0d", want.status, got.status);
      end
      if (got.granted_block !== want.granted_block) begin
        mismatches++;
        $error("granted_block: expected %0d, got %0d", want.granted_block, got.granted_block);
      end
      if (got.read_data !== want.read_data) begin
        mismatches++;
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
      end
      if (got.used_count !== want.used_count) begin
        mismatches++;
        $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
      end
      if (got.free_count !== want.free_count) begin
        mismatches++;
        $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bbas_req_if req_if ();
  bbas_rsp_if rsp_if ();

  bitmap_block_allocator_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  block_store_mirror mirror = new();

  // When this is low, neither side idles. One long phase runs that way.
  bit gaps_enabled = 1'b1;

  // A random read often goes back to the last written word, so stored data really comes back.
  logic [bbas_pkg::BLK_W-1:0]  last_write_id;
  logic [bbas_pkg::WIDX_W-1:0] last_write_widx;
  bit                          have_last_write = 1'b0;

  // Mostly random words, with all ones and all zeros mixed in.
  function automatic logic [bbas_pkg::DATA_W-1:0] random_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return WORD_ONES;
    if (roll < 15) return '0;
    return {$urandom(), $urandom()};
  endfunction

  // Returns a block in the wanted state, allocated or free, as the mirror sees it.
  // The search starts from a random place. If no block is in that state, any block
  // will do.
  function automatic logic [bbas_pkg::BLK_W-1:0] pick_block(bit want_taken);
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(bbas_pkg::NUM_BLOCKS - 1);
    for (int k = 0; k < bbas_pkg::NUM_BLOCKS; k++) begin
      idx = (start + k) % bbas_pkg::NUM_BLOCKS;
      if (mirror.block_taken[idx] == want_taken) return idx[bbas_pkg::BLK_W-1:0];
    end
    return start[bbas_pkg::BLK_W-1:0];
  endfunction

  // Builds one random request. The command mix follows the traffic mode. Block numbers
  // mostly name blocks in the state that takes the command past its error checks.
  // A few requests are noise: spare codes or the out-of-range number.
  function automatic store_request_t random_request(traffic_mode_e mode);
    store_request_t             req;
    int unsigned                roll;
    int unsigned                pick;
    logic [bbas_pkg::CMD_W-1:0] spare;
    roll           = $urandom_range(99);
    pick           = $urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST);
    spare          = pick[bbas_pkg::CMD_W-1:0];
    pick           = $urandom_range(255);
    req.blk_num    = pick[bbas_pkg::BLK_W-1:0];
    pick           = $urandom_range(31);
    req.word_index = pick[bbas_pkg::WIDX_W-1:0];
    req.write_data = random_word();
    case (mode)
      MODE_FILL:
        req.command = roll < 55 ? bbas_pkg::CMD_ALLOC : roll < 75 ? bbas_pkg::CMD_REQUEST :
                      roll < 85 ? bbas_pkg::CMD_WRITE : roll < 95 ? bbas_pkg::CMD_READ : spare;
      MODE_DRAIN:
        req.command = roll < 50 ? bbas_pkg::CMD_RELEASE : roll < 60 ? bbas_pkg::CMD_ALLOC :
                      roll < 75 ? bbas_pkg::CMD_WRITE : roll < 90 ? bbas_pkg::CMD_READ :
                      roll < 95 ? bbas_pkg::CMD_REQUEST : spare;
      default:
        req.command = roll < 20 ? bbas_pkg::CMD_ALLOC : roll < 35 ? bbas_pkg::CMD_REQUEST :
                      roll < 50 ? bbas_pkg::CMD_RELEASE : roll < 70 ? bbas_pkg::CMD_WRITE :
                      roll < 95 ? bbas_pkg::CMD_READ : spare;
    endcase
    roll = $urandom_range(99);
    case (req.command)
      bbas_pkg::CMD_REQUEST: if (roll < 70) req.blk_num = pick_block(1'b0);
      bbas_pkg::CMD_RELEASE: if (roll < 85) req.blk_num = pick_block(1'b1);
      bbas_pkg::CMD_READ: begin
        if (roll < 40 && have_last_write) begin
          req.blk_num    = last_write_id;
          req.word_index = last_write_widx;
        end else if (roll < 85) begin
          req.blk_num = pick_block(1'b1);
        end
      end
      bbas_pkg::CMD_WRITE: begin
        if (roll < 85) req.blk_num = pick_block(1'b1);
        last_write_id   = req.blk_num;
        last_write_widx = req.word_index;
        have_last_write = 1'b1;
      end
      default: ;
    endcase
    if ($urandom_range(99) < 3) req.blk_num = BLK_NUM_MAX;
    return req;
  endfunction

  // Offers one request and holds it until the block accepts it. Idle cycles are
  // inserted before it at random. The mirror sees the request at the edge that
  // accepts it. Ready is read just after the edge, so it still holds the value
  // the handshake used.
  task automatic send_request(input logic [bbas_pkg::CMD_W-1:0] command,
                              input logic [bbas_pkg::BLK_W-1:0] blk_num,
                              input logic [bbas_pkg::WIDX_W-1:0] word_index,
                              input logic [bbas_pkg::DATA_W-1:0] write_data);
    store_request_t req;
    req = '{command, blk_num, word_index, write_data};
    while (gaps_enabled && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= command;
    req_if.blk_num    <= blk_num;
    req_if.word_index <= word_index;
    req_if.write_data <= write_data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    mirror.note_request(req);
  endtask

  task automatic run_phase(input traffic_mode_e mode, input int unsigned count);
    store_request_t req;
    repeat (count) begin
      req = random_request(mode);
      send_request(req.command, req.blk_num, req.word_index, req.write_data);
    end
  endtask

  // Response side. Ready is dropped at random. A response counts at every edge
  // where valid and ready were both high.
  initial begin
    store_response_t seen;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        seen = '{bbas_pkg::status_e'(rsp_if.status), rsp_if.granted_block, rsp_if.read_data,
                 rsp_if.used_count, rsp_if.free_count};
        mirror.check_response(seen);
      end
      rsp_if.ready <= !(gaps_enabled && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog. A hung handshake or a missing response ends the run here.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [bbas_pkg::DATA_W-1:0] probe_word;
    req_if.valid      <= 1'b0;
    req_if.command    <= '0;
    req_if.blk_num    <= '0;
    req_if.word_index <= '0;
    req_if.write_data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The store is empty and the word store has just been cleared.
    probe_word = random_word();
    send_request(bbas_pkg::CMD_READ,    8'd0,        5'd0,  '0);   // read of a free block
    send_request(bbas_pkg::CMD_RELEASE, 8'd0,        5'd0,  '0);   // release of a free block
    send_request(bbas_pkg::CMD_ALLOC,   8'd0,        5'd0,  '0);   // lowest free is block 0
    send_request(bbas_pkg::CMD_ALLOC,   BLK_NUM_MAX, 5'd31, WORD_ONES);
    send_request(bbas_pkg::CMD_REQUEST, 8'd254,      5'd0,  '0);   // highest valid number
    send_request(bbas_pkg::CMD_REQUEST, BLK_NUM_MAX, 5'd0,  '0);   // number out of range
    send_request(bbas_pkg::CMD_REQUEST, 8'd1,        5'd0,  '0);   // block already taken
    send_request(bbas_pkg::CMD_RELEASE, BLK_NUM_MAX, 5'd0,  '0);
    send_request(bbas_pkg::CMD_WRITE,   BLK_NUM_MAX, 5'd31, WORD_ONES);
    send_request(bbas_pkg::CMD_READ,    BLK_NUM_MAX, 5'd0,  '0);
    send_request(bbas_pkg::CMD_WRITE,   8'd0,        5'd31, WORD_ONES);
    send_request(bbas_pkg::CMD_READ,    8'd0,        5'd31, '0);
    send_request(bbas_pkg::CMD_READ,    8'd0,        5'd0,  '0);   // zero since the clearing pass
    send_request(bbas_pkg::CMD_WRITE,   8'd100,      5'd5,  probe_word);  // write to a free block
    send_request(bbas_pkg::CMD_READ,    8'd100,      5'd5,  '0);   // refused: block is free
    send_request(bbas_pkg::CMD_REQUEST, 8'd100,      5'd0,  '0);
    send_request(bbas_pkg::CMD_READ,    8'd100,      5'd5,  '0);   // the earlier write is kept
    send_request(bbas_pkg::CMD_WRITE,   8'd254,      5'd0,  '0);
    send_request(bbas_pkg::CMD_RELEASE, 8'd1,        5'd0,  '0);
    send_request(bbas_pkg::CMD_ALLOC,   8'd0,        5'd0,  '0);   // refills the hole at block 1
    send_request(CMD_SPARE_FIRST, BLK_NUM_MAX, 5'd31, WORD_ONES);
    send_request(CMD_SPARE_FIRST + 3'd1, 8'd0, 5'd0, '0);
    send_request(CMD_SPARE_LAST,  8'd1,        5'd0,  WORD_ONES);
    send_request(bbas_pkg::CMD_RELEASE, 8'd254,      5'd0,  '0);

    // Random part. Fill runs long enough to reach a full store and to allocate
    // against it several times. The first drain phase runs with no idling on
    // either side.
    run_phase(MODE_MIX, 300);
    run_phase(MODE_FILL, 400);
    gaps_enabled = 1'b0;
    run_phase(MODE_DRAIN, 250);
    gaps_enabled = 1'b1;
    run_phase(MODE_DRAIN, 150);
    run_phase(MODE_MIX, 250);

    req_if.valid <= 1'b0;
    while (mirror.due_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[bitmap_block_allocator_store.f]
design/bbas_pkg.sv
design/bbas_req_if.sv
design/bbas_rsp_if.sv
design/bbas_ctrl.sv
design/bbas_dp.sv
design/bitmap_block_allocator_store.sv
bench/bitmap_block_allocator_store_test.sv
